@@ rtl/core/itr_pkg.sv @@
// itr_pkg: shared types, constants and the digit character map for the
// integer-to-text radix unit. No dependencies.
package itr_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned RADIX_W     = 6;
    localparam int unsigned BUFLEN_W    = 7;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGITS_MAX  = 32;
    localparam int unsigned DIGIT_IDX_W = 5;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned ROOM_W      = 8;
    localparam int unsigned DIV_CNT_W   = 5;

    localparam logic [RADIX_W-1:0]  RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0]  RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0]  RADIX_RESET   = 6'd10;
    localparam logic [BUFLEN_W-1:0] BUFLEN_RESET  = 7'd34;
    localparam logic [CHAR_W-1:0]   CHAR_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0]   CHAR_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0]   CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_LETTER_A = 8'h41;

    typedef enum logic [0:0] {
        REG_RADIX  = 1'b0,
        REG_BUFLEN = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [RADIX_W-1:0]   remainder;
    } div_result_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {2'b00, d};
        if (d < 6'd10)
            digit_char = CHAR_ZERO + dw;
        else
            digit_char = CHAR_LETTER_A + dw - 8'd10;
    endfunction

endpackage

@@ rtl/core/itr_divider.sv @@
// itr_divider: restoring divider, 32-bit dividend by 6-bit radix, one
// quotient bit per cycle. Depends on itr_pkg.
module itr_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [itr_pkg::VALUE_W-1:0]   dividend,
    input  logic [itr_pkg::RADIX_W-1:0]   divisor,
    output itr_pkg::div_result_t          result
);

    logic                              active_reg, active_next;
    logic                              done_reg, done_next;
    logic [itr_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [itr_pkg::VALUE_W-1:0]       quo_reg, quo_next;
    logic [itr_pkg::RADIX_W-1:0]       rem_reg, rem_next;
    logic [itr_pkg::RADIX_W:0]         trial;
    logic [itr_pkg::RADIX_W:0]         diff;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[itr_pkg::VALUE_W-1]};
    assign fits  = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            quo_next    = dividend;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            quo_next = {quo_reg[itr_pkg::VALUE_W-2:0], fits};
            rem_next = fits ? diff[itr_pkg::RADIX_W-1:0] : trial[itr_pkg::RADIX_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {itr_pkg::DIV_CNT_W{1'b1}})
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

@@ rtl/core/itr_digit_stack.sv @@
// itr_digit_stack: 32-entry character store, digits written least
// significant first and read back in reverse. Depends on itr_pkg.
module itr_digit_stack
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [itr_pkg::DIGIT_IDX_W-1:0]   wr_addr,
    input  logic [itr_pkg::CHAR_W-1:0]        wr_data,
    input  logic                              rd_en,
    input  logic [itr_pkg::DIGIT_IDX_W-1:0]   rd_addr,
    output logic [itr_pkg::CHAR_W-1:0]        rd_data
);

    logic [itr_pkg::CHAR_W-1:0] mem [itr_pkg::DIGITS_MAX];
    logic [itr_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/integer_to_text_radix_unit.sv @@
// integer_to_text_radix_unit: 32-bit integer to ASCII text, radix 2 to 36.
// Per digit, one pass of the shared 32-step divider; then a check
// state, an optional minus sign and one character per cycle. A bad radix or
// a zero buffer_length gives one error word in the cycle after start, too
// little room one after the check. Busy until the last word; no stall.
// Reset: async active low, radix 10, buffer_length 34, sequencer idle.
module integer_to_text_radix_unit
#(
    parameter int unsigned MAX_BUFFER = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [itr_pkg::VALUE_W-1:0]       value,
    output logic                              result_valid,
    output logic [itr_pkg::CHAR_W-1:0]        character,
    output logic                              last,
    output logic                              error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  itr_pkg::cfg_index_t               cfg_index,
    input  logic [itr_pkg::BUFLEN_W-1:0]      cfg_data
);

    localparam logic [itr_pkg::ROOM_W-1:0] ROOM_CAP = itr_pkg::ROOM_W'(MAX_BUFFER);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIVIDE = 6'b000010,
        S_CHECK  = 6'b000100,
        S_SIGN   = 6'b001000,
        S_EMIT   = 6'b010000,
        S_ERROR  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [itr_pkg::RADIX_W-1:0]       radix_reg;
    logic [itr_pkg::BUFLEN_W-1:0]      buflen_reg;
    logic                              neg_reg, neg_next;
    logic [itr_pkg::COUNT_W-1:0]       ndig_reg, ndig_next;
    logic [itr_pkg::COUNT_W-1:0]       k_reg, k_next;

    logic                              accept;
    logic                              cfg_bad;
    logic [itr_pkg::ROOM_W-1:0]        room;
    logic [itr_pkg::ROOM_W-1:0]        need;
    logic                              in_neg;
    logic [itr_pkg::VALUE_W-1:0]       magnitude;

    itr_pkg::div_result_t              div_res;
    logic                              div_start;
    logic [itr_pkg::VALUE_W-1:0]       div_dividend;

    logic                              wr_en;
    logic                              rd_en;
    logic [itr_pkg::COUNT_W-1:0]       rd_idx;
    logic [itr_pkg::CHAR_W-1:0]        rd_data;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    assign room    = ({1'b0, buflen_reg} > ROOM_CAP) ? ROOM_CAP : {1'b0, buflen_reg};
    assign cfg_bad = (room == '0) || (radix_reg < itr_pkg::RADIX_MIN)
                     || (radix_reg > itr_pkg::RADIX_MAX);
    assign need    = {2'b00, ndig_reg} + {7'd0, neg_reg} + 8'd1;

    assign in_neg    = mode && value[itr_pkg::VALUE_W-1];
    assign magnitude = in_neg ? (~value + 32'd1) : value;

    assign div_start    = (accept && !cfg_bad)
                          || ((state_reg == S_DIVIDE) && div_res.done
                              && (div_res.quotient != '0));
    assign div_dividend = accept ? magnitude : div_res.quotient;

    itr_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .result   (div_res)
    );

    assign wr_en  = (state_reg == S_DIVIDE) && div_res.done;
    assign rd_en  = (state_reg == S_CHECK) || (state_reg == S_EMIT);
    assign rd_idx = (state_reg == S_CHECK) ? (ndig_reg - 6'd1) : (k_reg - 6'd2);

    itr_digit_stack u_stack
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ndig_reg[itr_pkg::DIGIT_IDX_W-1:0]),
        .wr_data (itr_pkg::digit_char(div_res.remainder)),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[itr_pkg::DIGIT_IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = in_neg;
                    ndig_next  = '0;
                    state_next = cfg_bad ? S_ERROR : S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_res.done)
                begin
                    ndig_next = ndig_reg + 6'd1;
                    if (div_res.quotient == '0)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                k_next = ndig_reg;
                if (need > room)
                    state_next = S_ERROR;
                else
                    state_next = neg_reg ? S_SIGN : S_EMIT;
            end
            S_SIGN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                k_next = k_reg - 6'd1;
                if (k_reg == 6'd1)
                    state_next = S_IDLE;
            end
            S_ERROR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            radix_reg  <= itr_pkg::RADIX_RESET;
            buflen_reg <= itr_pkg::BUFLEN_RESET;
            ndig_reg   <= '0;
            k_reg      <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ndig_reg  <= ndig_next;
            k_reg     <= k_next;
            neg_reg   <= neg_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    itr_pkg::REG_RADIX:  radix_reg  <= cfg_data[itr_pkg::RADIX_W-1:0];
                    itr_pkg::REG_BUFLEN: buflen_reg <= cfg_data;
                    default:             radix_reg  <= radix_reg;
                endcase
            end
        end
    end

    assign result_valid = (state_reg == S_SIGN) || (state_reg == S_EMIT)
                          || (state_reg == S_ERROR);
    assign character    = (state_reg == S_SIGN) ? itr_pkg::CHAR_MINUS :
                          (state_reg == S_EMIT) ? rd_data : itr_pkg::CHAR_NUL;
    assign last         = ((state_reg == S_EMIT) && (k_reg == 6'd1))
                          || (state_reg == S_ERROR);
    assign error        = (state_reg == S_ERROR);

endmodule

@@ rtl/core/itr_checker.sv @@
// itr_checker: port-level checks for integer_to_text_radix_unit, bound to
// the top level below. Depends on itr_pkg.
module itr_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          result_valid,
    input  logic [itr_pkg::CHAR_W-1:0]    character,
    input  logic                          last,
    input  logic                          error
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_word_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside a run");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error) |-> (last && (character == itr_pkg::CHAR_NUL)))
        else $error("error word malformed");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("word after last");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last))
        else $error("run ended without a last word");

endmodule

bind integer_to_text_radix_unit itr_checker u_itr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .character    (character),
    .last         (last),
    .error        (error)
);
